>>> sv/ttsp_pkg.sv
// Shared types, codes and result builders for the tagged TLV stream parser.
// No dependencies; every other file of the block imports it.
package ttsp_pkg;

   localparam int unsigned TTSP_QUEUE_DEPTH = 4;
   localparam logic [31:0] TTSP_RESET_MAGIC = 32'h6472_6148;
   localparam logic [15:0] TTSP_ALL_ONES = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_EMPTY     = 3'd1,
      KIND_TERM      = 3'd2,
      KIND_END       = 3'd3,
      KIND_BAD_MAGIC = 3'd4,
      KIND_TRUNC     = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_blob;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] tag_id;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic        last_of_tag;
      logic [15:0] tag_count;
      logic        last_result;
   } rsp_type;

   // One accepted byte yields at most two responses; they travel together.
   typedef struct packed {
      rsp_type res0;
      rsp_type res1;
      logic    two;
   } entry_type;

   function automatic rsp_type status_rsp(kind_type kind, logic [15:0] count);
      rsp_type r;
      r.kind         = kind;
      r.tag_id       = '0;
      r.payload_byte = '0;
      r.byte_index   = '0;
      r.last_of_tag  = 1'b0;
      r.tag_count    = count;
      r.last_result  = 1'b0;
      return r;
   endfunction

   function automatic rsp_type data_rsp(kind_type kind, logic [15:0] tag,
                                        logic [7:0] data, logic [15:0] index,
                                        logic last);
      rsp_type r;
      r.kind         = kind;
      r.tag_id       = tag;
      r.payload_byte = data;
      r.byte_index   = index;
      r.last_of_tag  = last;
      r.tag_count    = '0;
      r.last_result  = 1'b0;
      return r;
   endfunction

endpackage

>>> sv/ttsp_front.sv
// Front end: byte-wise parser state machine and the magic register.
// Depends on ttsp_pkg; emits at most one queue entry (one or two responses) per byte.
module ttsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [31:0]         csr_write_data,
   input  logic                in_valid,
   input  ttsp_pkg::req_type   in_req,
   output logic                out_push,
   output ttsp_pkg::entry_type out_entry
);
   import ttsp_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  slot_ff, slot_in;
   logic        quiet_ff, quiet_in;   // skip after bad magic: no end status
   logic [23:0] shift_ff, shift_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] rec_ff, rec_in;
   logic [31:0] magic_ff;

   logic [31:0] word;
   logic [15:0] hdr_tag, hdr_len;
   logic        eob, last;
   logic        v0, v1;
   rsp_type     r0, r1;

   assign eob     = in_req.end_of_blob;
   assign word    = {in_req.data_byte, shift_ff};
   assign hdr_tag = word[15:0];
   assign hdr_len = word[31:16];
   assign last    = (rem_ff <= 16'd1);

   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      quiet_in = quiet_ff;
      shift_in = shift_ff;
      tag_in   = tag_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      rec_in   = rec_ff;
      v0       = 1'b0;
      v1       = 1'b0;
      r0       = status_rsp(KIND_END, rec_ff);
      r1       = status_rsp(KIND_END, rec_ff);

      unique case (phase_ff)
         PH_MAGIC, PH_HEADER: begin
            if (slot_ff == 2'd3) begin
               slot_in  = 2'd0;
               shift_in = '0;
               if (phase_ff == PH_MAGIC) begin
                  if (word != magic_ff) begin
                     r0       = status_rsp(KIND_BAD_MAGIC, rec_ff);
                     v0       = 1'b1;
                     phase_in = PH_SKIP;
                     quiet_in = 1'b1;
                  end else begin
                     phase_in = PH_HEADER;
                     v0       = eob;
                  end
               end else if ((hdr_tag == '0 && hdr_len == '0) ||
                            (hdr_tag == TTSP_ALL_ONES && hdr_len == TTSP_ALL_ONES)) begin
                  // terminator header
                  r0       = status_rsp(KIND_TERM, rec_ff);
                  v0       = 1'b1;
                  v1       = eob;
                  phase_in = PH_SKIP;
                  quiet_in = 1'b0;
               end else begin
                  if (rec_ff != TTSP_ALL_ONES) begin
                     rec_in = rec_ff + 16'd1;
                  end
                  tag_in = hdr_tag;
                  v0     = 1'b1;
                  if (hdr_len == '0) begin
                     r0 = data_rsp(KIND_EMPTY, hdr_tag, 8'd0, 16'd0, 1'b0);
                     r1 = status_rsp(KIND_END, rec_in);
                     v1 = eob;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     rem_in   = hdr_len;
                     pos_in   = '0;
                     r0       = status_rsp(KIND_TRUNC, rec_in);
                     v0       = eob;
                  end
               end
            end else begin
               case (slot_ff)
                  2'd0:    shift_in[7:0]   = in_req.data_byte;
                  2'd1:    shift_in[15:8]  = in_req.data_byte;
                  default: shift_in[23:16] = in_req.data_byte;
               endcase
               slot_in = slot_ff + 2'd1;
               v0      = eob;
               if (phase_ff == PH_MAGIC) begin
                  r0 = status_rsp(KIND_BAD_MAGIC, rec_ff);
               end
            end
         end
         PH_PAYLOAD: begin
            r0     = data_rsp(KIND_PAYLOAD, tag_ff, in_req.data_byte, pos_ff, last);
            v0     = 1'b1;
            pos_in = pos_ff + 16'd1;
            rem_in = last ? 16'd0 : rem_ff - 16'd1;
            if (last) begin
               phase_in = PH_HEADER;
            end
            r1 = status_rsp(last ? KIND_END : KIND_TRUNC, rec_ff);
            v1 = eob;
         end
         PH_SKIP: begin
            v0 = eob && !quiet_ff;
         end
         default: begin
            phase_in = PH_MAGIC;
         end
      endcase

      r0.last_result = !v1;
      r1.last_result = 1'b1;

      // end of blob: back to the start of a new blob
      if (eob) begin
         phase_in = PH_MAGIC;
         slot_in  = 2'd0;
         quiet_in = 1'b0;
         shift_in = '0;
         tag_in   = '0;
         rem_in   = '0;
         pos_in   = '0;
         rec_in   = '0;
      end
   end

   assign out_push       = in_valid && v0;
   assign out_entry.res0 = r0;
   assign out_entry.res1 = r1;
   assign out_entry.two  = v1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         slot_ff  <= 2'd0;
         quiet_ff <= 1'b0;
         shift_ff <= '0;
         tag_ff   <= '0;
         rem_ff   <= '0;
         pos_ff   <= '0;
         rec_ff   <= '0;
         magic_ff <= TTSP_RESET_MAGIC;
      end else begin
         if (in_valid) begin
            phase_ff <= phase_in;
            slot_ff  <= slot_in;
            quiet_ff <= quiet_in;
            shift_ff <= shift_in;
            tag_ff   <= tag_in;
            rem_ff   <= rem_in;
            pos_ff   <= pos_in;
            rec_ff   <= rec_in;
         end
         if (csr_write_en) begin
            magic_ff <= csr_write_data;
         end
      end
   end

endmodule

>>> sv/ttsp_queue.sv
// Small register queue of response entries between front and back ends.
// Depends on ttsp_pkg for the entry type.
module ttsp_queue #(
   parameter int unsigned Depth = ttsp_pkg::TTSP_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output ttsp_pkg::entry_type head_entry
);
   import ttsp_pkg::*;

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CW = $clog2(Depth + 1);

   entry_type     store_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(Depth));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(Depth))
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
                    (do_push && !do_pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count missed a push");

endmodule

>>> sv/ttsp_back.sv
// Back end: unpacks queue entries into single responses on the output port.
// Depends on ttsp_pkg; one response per cycle while entries wait and the consumer pops.
module ttsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ttsp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ttsp_pkg::rsp_type   rsp_data
);
   import ttsp_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      sub_ff, sub_in;     // second response of the entry on display
   logic      consume, advance, load;

   assign consume = valid_ff && rsp_pop && (sub_ff || !entry_ff.two);
   assign advance = valid_ff && rsp_pop && !sub_ff && entry_ff.two;
   assign load    = q_valid && (!valid_ff || consume);
   assign q_pop   = load;

   always_comb begin
      entry_in = load ? q_entry : entry_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = 1'b0;
      end else begin
         valid_in = valid_ff && !consume;
         sub_in   = advance || (sub_ff && !consume);
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = sub_ff ? entry_ff.res1 : entry_ff.res0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
      entry_ff <= entry_in;
   end

   assert property (@(posedge clock) disable iff (reset)
                    sub_ff |-> (valid_ff && entry_ff.two))
      else $error("second response shown for a single-response entry");

   assert property (@(posedge clock) disable iff (reset)
                    (valid_ff && !sub_ff && entry_ff.two) |-> !entry_ff.res0.last_result)
      else $error("first of two responses flagged as last");

endmodule

>>> sv/tagged_tlv_stream_parser_core.sv
// Top level of the tagged TLV stream parser: front parser, entry queue, back end.
// Depends on ttsp_pkg, ttsp_front, ttsp_queue and ttsp_back.
//
// Usage:
//  - Request side is a queue write port: drive req_data (one blob byte plus
//    the end-of-blob flag) and push; the byte is taken when push is high
//    and full is low. One byte per cycle is accepted while full is low.
//  - Response side is a queue read port: while empty is low, rsp_data holds
//    the oldest response; pop takes it. One response per cycle while empty is low.
//  - csr_write_en / csr_write_data load the expected magic word; write only
//    while the block is idle.
//  - Response path: the entry is written into the queue as its byte is taken,
//    then moves into the back end's output register once that register is free;
//    rsp_data is driven from that register.
//  - Throughput: one byte per cycle while full is low; a byte that yields two
//    responses (end of blob on a payload byte, on a terminator or on an empty
//    record) hands them out one after the other, absorbed by the entry queue.
//  - Consumer stall: responses wait in the output register and the queue;
//    full rises once the queue is full, so nothing is lost.
//  - Reset: parser back to expecting the magic word, magic register to its
//    default, queue and output empty.
module tagged_tlv_stream_parser_core #(
   parameter int unsigned QueueDepth = ttsp_pkg::TTSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ttsp_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output ttsp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data
);
   import ttsp_pkg::*;

   logic      req_take;      // request accepted this cycle
   logic      f_push;
   entry_type f_entry;
   logic      q_empty;
   logic      q_pop;
   entry_type q_head;

   assign req_take = push && !full;

   ttsp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .in_valid       (req_take),
      .in_req         (req_data),
      .out_push       (f_push),
      .out_entry      (f_entry)
   );

   // Full backs up the request side whole, so the front never loses an entry.
   ttsp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_entry (f_entry),
      .full       (full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_entry (q_head)
   );

   ttsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_empty),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule
